// ===== src/xmoa_pkg.sv =====
`timescale 1ns / 1ps
// types and constants for the x86 modrm operand address decoder
// no dependencies; used by xmoa_addr_gen and x86_modrm_operand_address
package xmoa_pkg;

   // mod field codes
   localparam logic [1:0] MOD_NO_DISP = 2'b00;
   localparam logic [1:0] MOD_DISP8   = 2'b01;
   localparam logic [1:0] MOD_DISP_W  = 2'b10;
   localparam logic [1:0] MOD_REG     = 2'b11;

   // register numbers with special meaning in rm, sib index and sib base
   localparam logic [2:0] REG_SP = 3'd4;
   localparam logic [2:0] REG_BP = 3'd5;
   localparam logic [2:0] RM_BP16 = 3'd6;

   localparam logic [3:0] BASE_LENGTH = 4'd3;

   typedef enum logic [1:0] {
      ST_MEMORY   = 2'd0,
      ST_REGISTER = 2'd1,
      ST_RANGE    = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0]  modrm;
      logic [39:0] tail_bytes;
      logic        addr32;
      logic        override_valid;
      logic [15:0] override_segment;
      logic [15:0] data_segment;
      logic [15:0] stack_segment;
      logic [63:0] regs_ax_cx;
      logic [63:0] regs_dx_bx;
      logic [63:0] regs_sp_bp;
      logic [63:0] regs_si_di;
   } req_type;

   typedef struct packed {
      logic [3:0]  insn_length;
      logic [20:0] linear_address;
      status_type  status;
   } rsp_type;

endpackage

// ===== src/xmoa_addr_gen.sv =====
`timescale 1ns / 1ps
// combinational effective address, length and status for one request
// depends on xmoa_pkg
module xmoa_addr_gen import xmoa_pkg::*; (
   input  req_type req,
   output rsp_type rsp
);

   function automatic logic [31:0] gpr(input req_type r, input logic [2:0] idx);
      logic [63:0] pair;
      case (idx[2:1])
         2'd0:    pair = r.regs_ax_cx;
         2'd1:    pair = r.regs_dx_bx;
         2'd2:    pair = r.regs_sp_bp;
         default: pair = r.regs_si_di;
      endcase
      return idx[0] ? pair[63:32] : pair[31:0];
   endfunction

   logic [1:0]  mod_f;
   logic [2:0]  rm;
   logic [7:0]  sib;
   logic [2:0]  sib_idx;
   logic [2:0]  sib_base;
   logic        has_sib;
   logic [31:0] idx_term;
   logic [31:0] base_term;
   logic [31:0] disp32;
   logic [7:0]  disp8;
   logic [31:0] ofs32;
   logic [15:0] base16;
   logic [15:0] disp16;
   logic [15:0] ofs16;
   logic [15:0] bx, bp, si, di;
   logic        use_ss;
   logic [3:0]  len;
   logic [15:0] seg;
   logic [15:0] ofs;
   logic        range_err;

   assign mod_f    = req.modrm[7:6];
   assign rm       = req.modrm[2:0];
   assign sib      = req.tail_bytes[7:0];
   assign sib_idx  = sib[5:3];
   assign sib_base = sib[2:0];
   assign bx = req.regs_dx_bx[47:32];
   assign bp = req.regs_sp_bp[47:32];
   assign si = req.regs_si_di[15:0];
   assign di = req.regs_si_di[47:32];

   always_comb begin
      has_sib   = 1'b0;
      idx_term  = '0;
      base_term = '0;
      disp32    = '0;
      disp8     = '0;
      base16    = '0;
      disp16    = '0;
      use_ss    = 1'b0;
      len       = BASE_LENGTH;
      if (req.addr32) begin
         has_sib = (rm == REG_SP);
         if (has_sib) begin
            len = len + 4'd1;
            if (sib_idx != REG_SP)
               idx_term = gpr(req, sib_idx) << sib[7:6];
            if (sib_base == REG_BP && mod_f == MOD_NO_DISP) begin
               base_term = req.tail_bytes[39:8];
               len       = len + 4'd4;
            end else begin
               base_term = gpr(req, sib_base);
               use_ss    = (sib_base == REG_SP) || (sib_base == REG_BP);
            end
         end else if (rm == REG_BP && mod_f == MOD_NO_DISP) begin
            base_term = req.tail_bytes[31:0];
            len       = len + 4'd4;
         end else begin
            base_term = gpr(req, rm);
            use_ss    = (rm == REG_BP);
         end
         // displacement follows the sib byte when there is one
         disp8 = has_sib ? req.tail_bytes[15:8] : req.tail_bytes[7:0];
         case (mod_f)
            MOD_DISP8: begin
               disp32 = {{24{disp8[7]}}, disp8};
               len    = len + 4'd1;
            end
            MOD_DISP_W: begin
               disp32 = has_sib ? req.tail_bytes[39:8] : req.tail_bytes[31:0];
               len    = len + 4'd4;
            end
            default: disp32 = '0;
         endcase
      end else begin
         case (rm)
            3'd0: base16 = bx + si;
            3'd1: base16 = bx + di;
            3'd2: begin base16 = bp + si; use_ss = 1'b1; end
            3'd3: begin base16 = bp + di; use_ss = 1'b1; end
            3'd4: base16 = si;
            3'd5: base16 = di;
            3'd6: begin
               if (mod_f == MOD_NO_DISP) begin
                  base16 = req.tail_bytes[15:0];
                  len    = len + 4'd2;
               end else begin
                  base16 = bp;
                  use_ss = 1'b1;
               end
            end
            default: base16 = bx;
         endcase
         case (mod_f)
            MOD_DISP8: begin
               disp16 = {{8{req.tail_bytes[7]}}, req.tail_bytes[7:0]};
               len    = len + 4'd1;
            end
            MOD_DISP_W: begin
               disp16 = req.tail_bytes[15:0];
               len    = len + 4'd2;
            end
            default: disp16 = '0;
         endcase
      end
   end

   assign ofs32     = idx_term + base_term + disp32;
   assign ofs16     = base16 + disp16;
   assign range_err = req.addr32 && (ofs32[31:16] != 16'd0);
   assign ofs       = req.addr32 ? ofs32[15:0] : ofs16;

   always_comb begin
      if (req.override_valid)
         seg = req.override_segment;
      else if (use_ss)
         seg = req.stack_segment;
      else
         seg = req.data_segment;
   end

   always_comb begin
      if (mod_f == MOD_REG) begin
         rsp.insn_length    = '0;
         rsp.linear_address = '0;
         rsp.status         = ST_REGISTER;
      end else if (range_err) begin
         rsp.insn_length    = '0;
         rsp.linear_address = '0;
         rsp.status         = ST_RANGE;
      end else begin
         rsp.insn_length    = len;
         rsp.linear_address = {1'b0, seg, 4'b0000} + {5'b00000, ofs};
         rsp.status         = ST_MEMORY;
      end
   end

endmodule

// ===== src/x86_modrm_operand_address.sv =====
`timescale 1ns / 1ps
// x86_modrm_operand_address: memory operand decoder for virtual-8086 mode
// depends on xmoa_pkg and xmoa_addr_gen
//
// a request carries the modrm byte, the five code bytes after it, the address
// size, an optional segment override, ds, ss and the eight general registers.
// the response gives instruction length, linear address (segment * 16 + offset)
// and a status: memory operand, register operand, or 32-bit offset above 0xffff.
// both channels are valid/ready. a request is captured in an input register,
// decoded by one pass of combinational logic and captured in the response
// register. one request per cycle is sustained; the only limit is the response
// register draining. when rsp_ready is low the response holds, the input
// register still takes one more request, and req_ready drops only once both
// registers are full. reset empties both registers; there is no other state.
module x86_modrm_operand_address import xmoa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type decoded;
   logic    out_free;
   logic    advance;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !out_free);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   xmoa_addr_gen u_addr_gen (
      .req (in_data_ff),
      .rsp (decoded)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready)
         in_data_ff <= req_data;
      if (advance)
         out_data_ff <= decoded;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTHESIS
   // a non-memory status never carries a length or an address
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_MEMORY |->
         rsp_data.insn_length == 4'd0 && rsp_data.linear_address == 21'd0)
      else $error("non-memory response with length or address");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_MEMORY |->
         rsp_data.insn_length >= 4'd3 && rsp_data.insn_length <= 4'd8)
      else $error("memory response with bad length");

   // a captured request waits in the input register until it moves on
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_data_ff))
      else $error("pending request lost");

   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff)
      else $error("request stalled with free storage");

   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("decoded request not presented");
`endif

endmodule

// ===== sim/tb_x86_modrm_operand_address.sv =====
`timescale 1ns / 1ps
// testbench for x86_modrm_operand_address: directed and random operand requests
// checked against an in-bench address predictor; depends on xmoa_pkg and the rtl

module tb_x86_modrm_operand_address import xmoa_pkg::*;;

   localparam int HOLD_CYCLES = 80;
   localparam int TIMEOUT_NS  = 5_000_000;

   // 16-bit addressing forms selected by the rm field
   localparam logic [2:0] RM16_BX_SI = 3'd0;
   localparam logic [2:0] RM16_BX_DI = 3'd1;
   localparam logic [2:0] RM16_BP_SI = 3'd2;
   localparam logic [2:0] RM16_BP_DI = 3'd3;
   localparam logic [2:0] RM16_SI    = 3'd4;
   localparam logic [2:0] RM16_DI    = 3'd5;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   rsp_type expected_results[$];
   int      error_count = 0;
   bit      sender_gaps = 1'b1;
   bit      receiver_stalls = 1'b1;
   bit      hold_off = 1'b0;

   x86_modrm_operand_address uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb_x86_modrm_operand_address: done, errors");
      $finish;
   end

   function automatic logic [31:0] gpr_value(req_type r, logic [2:0] n);
      logic [63:0] pair;
      case (n[2:1])
         2'd0: pair = r.regs_ax_cx;
         2'd1: pair = r.regs_dx_bx;
         2'd2: pair = r.regs_sp_bp;
         default: pair = r.regs_si_di;
      endcase
      return n[0] ? pair[63:32] : pair[31:0];
   endfunction

   function automatic rsp_type predict_operand(req_type r);
      rsp_type     res;
      logic [1:0]  md;
      logic [2:0]  rm;
      logic [7:0]  sib;
      logic [31:0] ofs;
      logic [15:0] seg;
      logic [15:0] bx, bp, si, di;
      logic [3:0]  pos;
      res = '0;
      md = r.modrm[7:6];
      rm = r.modrm[2:0];
      ofs = '0;
      seg = r.data_segment;
      pos = '0;
      if (md == MOD_REG) begin
         res.status = ST_REGISTER;
         return res;
      end
      if (r.addr32) begin
         if (rm == REG_SP) begin
            sib = r.tail_bytes[7:0];
            pos = 4'd1;
            if (sib[5:3] != REG_SP)
               ofs = gpr_value(r, sib[5:3]) << sib[7:6];
            if (sib[2:0] == REG_BP && md == MOD_NO_DISP) begin
               // no base, disp32 follows the sib byte
               ofs = ofs + r.tail_bytes[8 +: 32];
               pos = 4'd5;
            end else begin
               ofs = ofs + gpr_value(r, sib[2:0]);
               if (sib[2:0] == REG_SP || sib[2:0] == REG_BP)
                  seg = r.stack_segment;
            end
         end else if (rm == REG_BP && md == MOD_NO_DISP) begin
            ofs = r.tail_bytes[31:0];
            pos = 4'd4;
         end else begin
            ofs = gpr_value(r, rm);
            if (rm == REG_BP)
               seg = r.stack_segment;
         end
         if (md == MOD_DISP8) begin
            ofs = ofs + {{24{r.tail_bytes[8*pos+7]}}, r.tail_bytes[8*pos +: 8]};
            pos = pos + 4'd1;
         end else if (md == MOD_DISP_W) begin
            ofs = ofs + r.tail_bytes[8*pos +: 32];
            pos = pos + 4'd4;
         end
      end else begin
         bx = r.regs_dx_bx[47:32];
         bp = r.regs_sp_bp[47:32];
         si = r.regs_si_di[15:0];
         di = r.regs_si_di[47:32];
         case (rm)
            RM16_BX_SI: ofs = bx + si;
            RM16_BX_DI: ofs = bx + di;
            RM16_BP_SI: begin
               ofs = bp + si;
               seg = r.stack_segment;
            end
            RM16_BP_DI: begin
               ofs = bp + di;
               seg = r.stack_segment;
            end
            RM16_SI: ofs = si;
            RM16_DI: ofs = di;
            RM_BP16: begin
               if (md == MOD_NO_DISP) begin
                  ofs = r.tail_bytes[15:0];
                  pos = 4'd2;
               end else begin
                  ofs = bp;
                  seg = r.stack_segment;
               end
            end
            default: ofs = bx;
         endcase
         if (md == MOD_DISP8) begin
            ofs = ofs + {{24{r.tail_bytes[8*pos+7]}}, r.tail_bytes[8*pos +: 8]};
            pos = pos + 4'd1;
         end else if (md == MOD_DISP_W) begin
            ofs = ofs + r.tail_bytes[8*pos +: 16];
            pos = pos + 4'd2;
         end
         ofs = ofs & 32'h0000_ffff;
      end
      if (ofs > 32'h0000_ffff) begin
         res.status = ST_RANGE;
         return res;
      end
      if (r.override_valid)
         seg = r.override_segment;
      res.insn_length = BASE_LENGTH + pos;
      res.linear_address = {1'b0, seg, 4'h0} + ofs[20:0];
      res.status = ST_MEMORY;
      return res;
   endfunction

   // compare the oldest prediction before queuing the one for this edge
   always @(posedge clock) begin : scoreboard
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("response with no request pending: %h", rsp_data);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.insn_length !== want.insn_length) begin
                  $error("insn_length: expected %0d, actual %0d",
                         want.insn_length, rsp_data.insn_length);
                  error_count++;
               end
               if (rsp_data.linear_address !== want.linear_address) begin
                  $error("linear_address: expected %h, actual %h",
                         want.linear_address, rsp_data.linear_address);
                  error_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_results.push_back(predict_operand(req_data));
      end
   end

   initial begin : response_sink
      int n;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            for (n = 0; n < HOLD_CYCLES; n++)
               @(posedge clock);
            hold_off = 1'b0;
         end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // valid stays up between back-to-back requests; it only drops for a gap
   task automatic send_request(input req_type r);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic req_type form_request(logic [7:0] modrm, logic addr32,
                                            logic [39:0] tail);
      req_type r;
      r = '0;
      r.modrm = modrm;
      r.addr32 = addr32;
      r.tail_bytes = tail;
      r.data_segment = 16'h1234;
      r.stack_segment = 16'h5678;
      r.override_segment = 16'h9abc;
      r.regs_ax_cx = {32'h0000_0110, 32'h0000_0100};
      r.regs_dx_bx = {32'h0000_0230, 32'h0000_0220};
      r.regs_sp_bp = {32'h0000_0340, 32'h0000_0330};
      r.regs_si_di = {32'h0000_0450, 32'h0000_0440};
      // upper halves must be ignored in 16-bit mode
      if (!addr32) begin
         r.regs_ax_cx = r.regs_ax_cx | {2{32'ha5a5_0000}};
         r.regs_dx_bx = r.regs_dx_bx | {2{32'ha5a5_0000}};
         r.regs_sp_bp = r.regs_sp_bp | {2{32'ha5a5_0000}};
         r.regs_si_di = r.regs_si_di | {2{32'ha5a5_0000}};
      end
      return r;
   endfunction

   function automatic req_type random_request();
      req_type     r;
      logic [31:0] g [8];
      logic [63:0] w;
      int          k;
      w = {$urandom, $urandom};
      r.tail_bytes = w[39:0];
      r.modrm = 8'($urandom_range(0, 255));
      r.modrm[7:6] = ($urandom_range(0, 9) == 0) ? MOD_REG : 2'($urandom_range(0, 2));
      r.addr32 = 1'($urandom_range(0, 1));
      r.override_valid = ($urandom_range(0, 3) == 0);
      r.override_segment = 16'($urandom_range(0, 65535));
      r.data_segment = 16'($urandom_range(0, 65535));
      r.stack_segment = 16'($urandom_range(0, 65535));
      // mostly small registers so 32-bit sums stay inside the segment
      for (k = 0; k < 8; k++) begin
         case ($urandom_range(0, 9))
            0, 1: g[k] = $urandom;
            2: g[k] = 32'hffff_0000 | $urandom_range(0, 65535);
            default: g[k] = $urandom_range(0, 16'h3fff);
         endcase
      end
      r.regs_ax_cx = {g[1], g[0]};
      r.regs_dx_bx = {g[3], g[2]};
      r.regs_sp_bp = {g[5], g[4]};
      r.regs_si_di = {g[7], g[6]};
      if (r.addr32) begin
         case ($urandom_range(0, 3))
            0: ;
            1: r.tail_bytes[39:16] = 24'hff_ffff;
            default: r.tail_bytes[39:16] = '0;
         endcase
      end
      return r;
   endfunction

   task automatic test_directed_forms();
      req_type    r;
      logic [1:0] md;
      int         i;
      send_request(form_request({MOD_REG, 3'd0, 3'd0}, 1'b0, 40'h0));
      send_request(form_request({MOD_REG, 3'd7, 3'd7}, 1'b1, 40'hff_ffff_ffff));
      // each 16-bit form, cycling through the displacement sizes
      for (i = 0; i < 8; i++) begin
         md = (i % 3 == 0) ? MOD_NO_DISP : (i % 3 == 1) ? MOD_DISP8 : MOD_DISP_W;
         send_request(form_request({md, 3'd2, i[2:0]}, 1'b0, 40'h00_0000_9c7f));
      end
      send_request(form_request({MOD_DISP8, 3'd0, RM_BP16}, 1'b0, 40'h80));
      send_request(form_request({MOD_DISP_W, 3'd0, RM_BP16}, 1'b0, 40'h00_0000_8001));
      // 16-bit sum wraps around the segment
      r = form_request({MOD_DISP_W, 3'd0, RM16_BX_SI}, 1'b0, 40'hffff);
      r.regs_dx_bx[47:32] = 16'hffff;
      r.regs_si_di[15:0] = 16'hffff;
      send_request(r);
      send_request(form_request({MOD_NO_DISP, 3'd0, REG_BP}, 1'b1, 40'h00_0000_fedc));
      send_request(form_request({MOD_DISP8, 3'd0, REG_BP}, 1'b1, 40'hf0));
      // sib: no index with esp base, no base with scaled index, ebp base
      send_request(form_request({MOD_NO_DISP, 3'd0, REG_SP}, 1'b1, {32'h0, 2'd2, REG_SP, REG_SP}));
      send_request(form_request({MOD_NO_DISP, 3'd0, REG_SP}, 1'b1, 40'h00_0010_00cd));
      send_request(form_request({MOD_DISP_W, 3'd0, REG_SP}, 1'b1, 40'h00_0000_1075));
      r = form_request({MOD_NO_DISP, 3'd0, 3'd0}, 1'b1, 40'h0);
      r.regs_ax_cx[31:0] = 32'h0001_0000;
      send_request(r);
      // 32-bit sum wraps back to a small offset
      r = form_request({MOD_DISP8, 3'd0, 3'd0}, 1'b1, 40'h02);
      r.regs_ax_cx[31:0] = 32'hffff_ffff;
      send_request(r);
      r = form_request({MOD_DISP8, 3'd0, RM_BP16}, 1'b0, 40'h10);
      r.override_valid = 1'b1;
      send_request(r);
      r = '1;
      r.modrm = {MOD_DISP_W, 3'd7, REG_SP};
      send_request(r);
      r = '1;
      r.modrm = {MOD_DISP_W, 3'd7, RM16_BX_SI};
      r.addr32 = 1'b0;
      send_request(r);
      send_request('0);
   endtask

   task automatic test_random_operands(input int count);
      repeat (count) send_request(random_request());
   endtask

   task automatic test_output_backpressure();
      sender_gaps = 1'b0;
      hold_off = 1'b1;
      repeat (24) send_request(random_request());
      while (hold_off) @(posedge clock);
   endtask

   task automatic test_random_streaming(input int count);
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      repeat (count) send_request(random_request());
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_forms();
      test_random_operands(700);
      test_output_backpressure();
      test_random_streaming(450);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (error_count == 0)
         $display("tb_x86_modrm_operand_address: done, clean");
      else
         $display("tb_x86_modrm_operand_address: done, errors");
      $finish;
   end

endmodule
